// ===== rtl/core/cft_pkg.sv =====
// shared types and constants for the csv field tokenizer
package cft_pkg;

  // character codes used by the integer check
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // register reset values
  localparam logic [7:0] DELIM_RESET = 8'd44;
  localparam logic [7:0] QUOTE_RESET = 8'd34;

  // magnitude limits of a signed 32-bit value
  localparam logic [31:0] INT_NEG_MAG = 32'h8000_0000;
  localparam logic [31:0] INT_POS_MAG = 32'h7FFF_FFFF;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_DELIM = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUOTE = 2'd1;

  // result queue depth, room for two pushes per cycle
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;
  localparam int unsigned QUEUE_CW    = 3;

  // result kinds
  localparam logic KIND_CONTENT = 1'b0;
  localparam logic KIND_END     = 1'b1;

  typedef struct packed {
    logic [7:0] char_in;
    logic       end_of_line;
  } cft_in_t;

  typedef struct packed {
    logic               kind;
    logic [7:0]         char_out;
    logic               is_integer;
    logic signed [31:0] int_value;
    logic               line_end;
    logic               last;
  } cft_out_t;

  // per-field integer tracking
  typedef struct packed {
    logic [31:0] magnitude_acc;
    logic        negative_sign;
    logic        digits_seen;
    logic        int_possible;
    logic        field_started;
  } cft_field_t;

  // quoting and field state carried between items
  typedef struct packed {
    logic       in_quotes;
    logic       quote_pending;
    cft_field_t field;
  } cft_state_t;

  localparam cft_field_t FIELD_CLEAR = '{
    magnitude_acc: 32'd0,
    negative_sign: 1'b0,
    digits_seen:   1'b0,
    int_possible:  1'b1,
    field_started: 1'b0
  };

endpackage

// ===== rtl/core/cft_field_eval.sv =====
// per-item decode: quoting, integer check and up to two results
module cft_field_eval (
  input  cft_pkg::cft_in_t    item,
  input  logic [7:0]          delimiter_char,
  input  logic [7:0]          quote_char,
  input  cft_pkg::cft_state_t state,
  output cft_pkg::cft_state_t state_nxt,
  output cft_pkg::cft_out_t   res0,
  output cft_pkg::cft_out_t   res1,
  output logic [1:0]          res_cnt
);
  import cft_pkg::*;

  logic [7:0] c;
  logic       eol;
  logic       is_delim;
  logic       is_quote;
  logic       unq;
  logic       do_content;
  logic       do_delim;
  logic       quote_eol;
  logic       open_quote;
  logic       set_pending;
  logic       is_sign;
  logic       is_digit;
  logic [35:0] mag_wide;
  cft_field_t content_fld;
  cft_out_t   content_res;
  cft_out_t   end_cur;
  cft_out_t   end_after;
  cft_out_t   end_empty;

  // build an end-of-field result from a field state
  function automatic cft_out_t field_end(input cft_field_t f, input logic closes);
    cft_out_t r;
    logic     ok;
    ok = f.int_possible && f.digits_seen &&
         (f.negative_sign ? (f.magnitude_acc <= INT_NEG_MAG)
                          : (f.magnitude_acc <= INT_POS_MAG));
    r.kind       = KIND_END;
    r.char_out   = 8'd0;
    r.is_integer = ok;
    r.int_value  = !ok ? 32'sd0 :
                   f.negative_sign ? $signed(32'd0 - f.magnitude_acc)
                                   : $signed(f.magnitude_acc);
    r.line_end   = closes;
    r.last       = 1'b0;
    return r;
  endfunction

  assign c        = item.char_in;
  assign eol      = item.end_of_line;
  assign is_delim = (c == delimiter_char);
  assign is_quote = (c == quote_char);

  // byte handled as outside quotes, also after a closing quote
  assign unq = !state.in_quotes || (state.quote_pending && !is_quote);

  // classify the byte
  assign do_content = (unq && !is_delim && !is_quote) ||
                      (state.in_quotes && state.quote_pending && is_quote) ||
                      (state.in_quotes && !state.quote_pending && !is_quote);
  assign do_delim   = unq && is_delim;
  assign open_quote = unq && !is_delim && is_quote;
  assign set_pending = state.in_quotes && !state.quote_pending && is_quote;
  assign quote_eol  = (open_quote || set_pending) && eol;

  // integer accumulation on a content byte
  assign is_sign  = !state.field.field_started && (c == CHAR_MINUS || c == CHAR_PLUS);
  assign is_digit = (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  assign mag_wide = {1'b0, state.field.magnitude_acc, 3'b000} +
                    {3'b000, state.field.magnitude_acc, 1'b0} +
                    {32'd0, c[3:0]};

  always_comb begin
    content_fld = state.field;
    if (is_sign) begin
      content_fld.negative_sign = (c == CHAR_MINUS);
    end else if (is_digit) begin
      content_fld.digits_seen = 1'b1;
      if (mag_wide > {4'd0, INT_NEG_MAG}) begin
        content_fld.int_possible  = 1'b0;
        content_fld.magnitude_acc = 32'd0;
      end else begin
        content_fld.magnitude_acc = mag_wide[31:0];
      end
    end else begin
      content_fld.int_possible = 1'b0;
    end
    content_fld.field_started = 1'b1;
  end

  // candidate results
  always_comb begin
    content_res            = '0;
    content_res.kind       = KIND_CONTENT;
    content_res.char_out   = c;
    end_cur   = field_end(state.field, !do_delim);
    end_after = field_end(content_fld, 1'b1);
    end_empty = field_end(FIELD_CLEAR, 1'b1);
  end

  // pick results and next state
  always_comb begin
    res0    = '0;
    res1    = '0;
    res_cnt = 2'd0;
    state_nxt = state;
    if (do_content) begin
      res0    = content_res;
      res1    = end_after;
      res_cnt = eol ? 2'd2 : 2'd1;
      state_nxt.field = eol ? FIELD_CLEAR : content_fld;
    end else if (do_delim) begin
      res0    = end_cur;
      res1    = end_empty;
      res_cnt = eol ? 2'd2 : 2'd1;
      state_nxt.field = FIELD_CLEAR;
    end else if (quote_eol) begin
      res0    = end_cur;
      res_cnt = 2'd1;
      state_nxt.field = FIELD_CLEAR;
    end
    res0.last = (res_cnt == 2'd1);
    res1.last = 1'b1;

    // quoting state
    if (eol) begin
      state_nxt.in_quotes     = 1'b0;
      state_nxt.quote_pending = 1'b0;
    end else begin
      state_nxt.in_quotes     = open_quote || (state.in_quotes && !unq);
      state_nxt.quote_pending = set_pending;
    end
  end

endmodule

// ===== rtl/core/cft_out_queue.sv =====
// result queue: up to two pushes and one pop per cycle
module cft_out_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  cft_pkg::cft_out_t push0,
  input  cft_pkg::cft_out_t push1,
  input  logic [1:0]        push_cnt,
  output logic              room2,
  output logic              head_valid,
  output cft_pkg::cft_out_t head,
  input  logic              pop
);
  import cft_pkg::*;

  cft_out_t             mem [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]  wr_r, wr_nxt;
  logic [QUEUE_AW-1:0]  rd_r, rd_nxt;
  logic [QUEUE_CW-1:0]  cnt_r, cnt_nxt;
  logic                 do_pop;

  assign head_valid = (cnt_r != '0);
  assign head       = mem[rd_r];
  assign room2      = (cnt_r <= QUEUE_CW'(QUEUE_DEPTH - 2));
  assign do_pop     = pop && head_valid;

  // pointer and count update
  always_comb begin
    wr_nxt  = wr_r + QUEUE_AW'(push_cnt);
    rd_nxt  = rd_r + QUEUE_AW'(do_pop);
    cnt_nxt = cnt_r + QUEUE_CW'(push_cnt) - QUEUE_CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem[wr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem[wr_r + QUEUE_AW'(1)] <= push1;
    end
  end

endmodule

// ===== rtl/core/csv_field_tokenizer_top.sv =====
// top level of the csv field tokenizer
//
//   port group  direction  handshake            payload
//   in_         input      in_valid / in_stall   cft_in_t  (char_in, end_of_line)
//   out_        output     out_valid / out_stall cft_out_t (kind .. last)
//   cfg_        input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item per cycle while in_stall is low: an item is held in the input register, is decoded
// there and its zero, one or two results land in a four-entry result queue.
// the queue drains one result per cycle while out_stall is low, so lines with many field ends
// (two results per item) run at the output rate.
// rst_n is synchronous; it restores the default delimiter and quote bytes.
// in_stall rises only when the queue lacks room for two results.
module csv_field_tokenizer_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  cft_pkg::cft_in_t                in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output cft_pkg::cft_out_t               out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [cft_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [7:0]                      cfg_data
);
  import cft_pkg::*;

  logic       delim_sel;
  logic [7:0] delimiter_r;
  logic [7:0] quote_r;
  logic       hold_v_r;
  cft_in_t    hold_r;
  cft_state_t state_r;
  cft_state_t state_nxt;
  cft_out_t   res0;
  cft_out_t   res1;
  logic [1:0] res_cnt;
  logic [1:0] push_cnt;
  logic       room2;
  logic       advance;
  logic       in_take;

  // configuration registers, always writable
  assign cfg_ready = 1'b1;
  assign delim_sel = cfg_valid && (cfg_index == CFG_DELIM);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      delimiter_r <= DELIM_RESET;
      quote_r     <= QUOTE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      if (delim_sel) begin
        delimiter_r <= cfg_data;
      end
      if (cfg_index == CFG_QUOTE) begin
        quote_r <= cfg_data;
      end
    end
  end

  // input register handshake
  assign advance  = hold_v_r && room2;
  assign in_stall = hold_v_r && !room2;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_v_r <= 1'b0;
    end else begin
      hold_v_r <= in_take || (hold_v_r && !advance);
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      hold_r <= in_data;
    end
  end

  // decode of the held item
  cft_field_eval u_eval (
    .item           (hold_r),
    .delimiter_char (delimiter_r),
    .quote_char     (quote_r),
    .state          (state_r),
    .state_nxt      (state_nxt),
    .res0           (res0),
    .res1           (res1),
    .res_cnt        (res_cnt)
  );

  // tokenizer state advances with each decoded item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r.in_quotes     <= 1'b0;
      state_r.quote_pending <= 1'b0;
      state_r.field         <= FIELD_CLEAR;
    end else if (advance) begin
      state_r <= state_nxt;
    end
  end

  assign push_cnt = advance ? res_cnt : 2'd0;

  // result queue
  cft_out_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push0      (res0),
    .push1      (res1),
    .push_cnt   (push_cnt),
    .room2      (room2),
    .head_valid (out_valid),
    .head       (out_data),
    .pop        (!out_stall)
  );

endmodule

// ===== sim/tb_csv_field_tokenizer_top.sv =====
// self-checking testbench for the csv field tokenizer top level
`timescale 1ns / 100ps

module tb_csv_field_tokenizer_top;
  import cft_pkg::*;

  // one row of the opening stimulus, with optional hand-written results
  typedef struct packed {
    logic [7:0] chr;
    logic       eol;
    logic [1:0] n_fix;
    cft_out_t   fix0;
    cft_out_t   fix1;
  } stim_row_t;

  localparam cft_out_t NO_RES        = '0;
  localparam cft_out_t END_MIN_INT   = '{KIND_END, 8'h00, 1'b1, 32'sh8000_0000, 1'b0, 1'b0};
  localparam cft_out_t END_NOINT_EOL = '{KIND_END, 8'h00, 1'b0, 32'sd0, 1'b1, 1'b1};
  localparam cft_out_t END_NOINT     = '{KIND_END, 8'h00, 1'b0, 32'sd0, 1'b0, 1'b1};
  localparam cft_out_t END_NINE_EOL  = '{KIND_END, 8'h00, 1'b1, 32'sd9, 1'b1, 1'b1};
  localparam cft_out_t CONTENT_FF    = '{KIND_CONTENT, 8'hFF, 1'b0, 32'sd0, 1'b0, 1'b0};
  localparam cft_out_t CONTENT_NINE  = '{KIND_CONTENT, 8'h39, 1'b0, 32'sd0, 1'b0, 1'b0};

  localparam int PHASES      = 6;
  localparam int PHASE_ITEMS = 200;
  localparam int SETTLE      = 8;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  cft_in_t   in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  cft_out_t  out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  // predictor state and configuration
  cft_state_t tok_st;
  logic [7:0] tok_delim;
  logic [7:0] tok_quote;
  cft_out_t   tok_res [2];
  int         tok_cnt;

  cft_out_t   tokens_due [$];
  logic [7:0] line_q [$];
  int         fail_count = 0;
  int         send_idle_pct = 0;
  int         recv_idle_pct = 0;

  // default config: "-2147483648," / quoting with doubled quote / byte 0xff /
  // byte 0x00, "+9" / line end inside quotes
  stim_row_t opening_rows [0:24] = '{
    '{8'h2D, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h32, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h31, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h34, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h37, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h34, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h38, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h33, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h36, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h34, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h38, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h2C, 1'b1, 2'd2, END_MIN_INT, END_NOINT_EOL},
    '{8'h22, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h22, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h22, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h22, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h37, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h22, 1'b1, 2'd1, END_NOINT_EOL, NO_RES},
    '{8'hFF, 1'b1, 2'd2, CONTENT_FF, END_NOINT_EOL},
    '{8'h00, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h2C, 1'b0, 2'd1, END_NOINT, NO_RES},
    '{8'h2B, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h39, 1'b1, 2'd2, CONTENT_NINE, END_NINE_EOL},
    '{8'h22, 1'b0, 2'd0, NO_RES, NO_RES},
    '{8'h71, 1'b1, 2'd0, NO_RES, NO_RES}
  };

  logic [7:0] phase_delim [PHASES] = '{8'd44, 8'd0, 8'd255, 8'd59, 8'd124, 8'd0};
  logic [7:0] phase_quote [PHASES] = '{8'd34, 8'd255, 8'd0, 8'd39, 8'd124, 8'd0};

  csv_field_tokenizer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // content byte result and integer tracking
  task automatic emit_char(input logic [7:0] c);
    logic [35:0] wide;
    tok_res[tok_cnt] = '0;
    tok_res[tok_cnt].kind = KIND_CONTENT;
    tok_res[tok_cnt].char_out = c;
    tok_cnt++;
    if (!tok_st.field.field_started && (c == CHAR_MINUS || c == CHAR_PLUS)) begin
      tok_st.field.negative_sign = (c == CHAR_MINUS);
    end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
      wide = {4'b0, tok_st.field.magnitude_acc} * 36'd10 + {28'b0, c} - {28'b0, CHAR_ZERO};
      tok_st.field.digits_seen = 1'b1;
      if (wide > {4'b0, INT_NEG_MAG}) begin
        tok_st.field.int_possible = 1'b0;
        tok_st.field.magnitude_acc = '0;
      end else begin
        tok_st.field.magnitude_acc = wide[31:0];
      end
    end else begin
      tok_st.field.int_possible = 1'b0;
    end
    tok_st.field.field_started = 1'b1;
  endtask

  // end of field result with the integer verdict
  task automatic emit_field_end(input logic closes);
    logic ok;
    logic [31:0] mag;
    mag = tok_st.field.magnitude_acc;
    ok = tok_st.field.int_possible && tok_st.field.digits_seen &&
         (tok_st.field.negative_sign ? mag <= INT_NEG_MAG : mag <= INT_POS_MAG);
    tok_res[tok_cnt] = '0;
    tok_res[tok_cnt].kind = KIND_END;
    tok_res[tok_cnt].is_integer = ok;
    if (ok) tok_res[tok_cnt].int_value = tok_st.field.negative_sign ? 32'd0 - mag : mag;
    tok_res[tok_cnt].line_end = closes;
    tok_cnt++;
    tok_st.field = FIELD_CLEAR;
  endtask

  // byte seen outside quoted text; delimiter wins over quote
  task automatic take_unquoted(input logic [7:0] c, input logic eol);
    if (c == tok_delim) begin
      emit_field_end(1'b0);
      if (eol) emit_field_end(1'b1);
    end else if (c == tok_quote) begin
      if (eol) emit_field_end(1'b1);
      else tok_st.in_quotes = 1'b1;
    end else begin
      emit_char(c);
      if (eol) emit_field_end(1'b1);
    end
  endtask

  // expected results of one input item
  task automatic tokenize_char(input logic [7:0] c, input logic eol);
    tok_cnt = 0;
    if (!tok_st.in_quotes) begin
      take_unquoted(c, eol);
    end else if (tok_st.quote_pending) begin
      tok_st.quote_pending = 1'b0;
      if (c == tok_quote) begin
        emit_char(c);
        if (eol) emit_field_end(1'b1);
      end else begin
        tok_st.in_quotes = 1'b0;
        take_unquoted(c, eol);
      end
    end else if (c == tok_quote) begin
      if (eol) emit_field_end(1'b1);
      else tok_st.quote_pending = 1'b1;
    end else begin
      emit_char(c);
      if (eol) emit_field_end(1'b1);
    end
    if (eol) begin
      tok_st.in_quotes = 1'b0;
      tok_st.quote_pending = 1'b0;
    end
    if (tok_cnt > 0) tok_res[tok_cnt-1].last = 1'b1;
  endtask

  task automatic report_bad(input string what, input cft_out_t want, input cft_out_t got);
    fail_count++;
    if (fail_count <= 10)
      $display("mismatch (%s): ", what,
               "expected kind=%0b char=%02h int=%0b val=%0d eol=%0b last=%0b, ",
               want.kind, want.char_out, want.is_integer, want.int_value,
               want.line_end, want.last,
               "got kind=%0b char=%02h int=%0b val=%0d eol=%0b last=%0b",
               got.kind, got.char_out, got.is_integer, got.int_value,
               got.line_end, got.last);
  endtask

  // drive one item, wait for acceptance, record its expected results
  task automatic send_item(input logic [7:0] c, input logic eol, input logic [1:0] n_fix,
                           input cft_out_t fix0, input cft_out_t fix1);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= '{char_in: c, end_of_line: eol};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    tokenize_char(c, eol);
    if (n_fix == 2'd0) begin
      for (int k = 0; k < tok_cnt; k++) tokens_due.push_back(tok_res[k]);
    end else begin
      tokens_due.push_back(fix0);
      if (n_fix == 2'd2) tokens_due.push_back(fix1);
    end
  endtask

  // let the block drain before touching its registers
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (tokens_due.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == CFG_DELIM) tok_delim = val;
    else if (idx == CFG_QUOTE) tok_quote = val;
  endtask

  // one random line: mostly well-formed fields, sometimes raw noise
  task automatic build_line();
    int n_fields;
    int len;
    longint val;
    string digits;
    line_q.delete();
    if ($urandom_range(9) == 0) begin
      len = $urandom_range(1, 8);
      repeat (len) begin
        case ($urandom_range(5))
          0: line_q.push_back(tok_delim);
          1: line_q.push_back(tok_quote);
          default: line_q.push_back(8'($urandom_range(255)));
        endcase
      end
      return;
    end
    n_fields = $urandom_range(1, 5);
    for (int f = 0; f < n_fields; f++) begin
      if (f != 0) line_q.push_back(tok_delim);
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          case ($urandom_range(9))
            0: val = 64'sd2147483647;
            1: val = -64'sd2147483648;
            2: val = 64'sd2147483648;
            3: val = -64'sd2147483649;
            4: val = 64'sd98765432109;
            5, 6: val = longint'($urandom_range(0, 999)) - 500;
            default: val = $signed($urandom);
          endcase
          digits = $sformatf("%0d", (val < 0) ? -val : val);
          if (val < 0) line_q.push_back(CHAR_MINUS);
          else if ($urandom_range(3) == 0) line_q.push_back(CHAR_PLUS);
          if ($urandom_range(7) == 0) line_q.push_back(CHAR_ZERO);
          for (int k = 0; k < digits.len(); k++) line_q.push_back(digits[k]);
        end
        4, 5: begin
          line_q.push_back(tok_quote);
          len = $urandom_range(0, 6);
          repeat (len) begin
            if ($urandom_range(4) == 0) begin
              line_q.push_back(tok_quote);
              line_q.push_back(tok_quote);
            end else begin
              line_q.push_back(8'($urandom_range(32, 126)));
            end
          end
          line_q.push_back(tok_quote);
        end
        6: ;
        7, 8: begin
          len = $urandom_range(1, 6);
          repeat (len) line_q.push_back(8'($urandom_range(255)));
        end
        default: begin
          line_q.push_back(8'($urandom_range(97, 122)));
          line_q.push_back(tok_quote);
          line_q.push_back(8'($urandom_range(48, 57)));
          line_q.push_back(tok_quote);
          line_q.push_back(8'($urandom_range(97, 122)));
        end
      endcase
    end
    if (line_q.size() == 0) line_q.push_back(8'($urandom_range(255)));
  endtask

  // receiver stall pattern
  always @(posedge clk) out_stall <= ($urandom_range(99) < recv_idle_pct);

  // result check against the oldest expected item
  always @(posedge clk) begin
    cft_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (tokens_due.size() == 0) begin
        report_bad("unexpected result", NO_RES, out_data);
      end else begin
        want = tokens_due.pop_front();
        if (out_data.kind !== want.kind || out_data.char_out !== want.char_out ||
            out_data.is_integer !== want.is_integer || out_data.int_value !== want.int_value ||
            out_data.line_end !== want.line_end || out_data.last !== want.last)
          report_bad("field", want, out_data);
      end
    end
  end

  // stimulus and end of run
  initial begin
    int sent;
    int drain;
    tok_st = '{in_quotes: 1'b0, quote_pending: 1'b0, field: FIELD_CLEAR};
    tok_delim = DELIM_RESET;
    tok_quote = QUOTE_RESET;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_idle_pct = 31;
    recv_idle_pct = 54;
    foreach (opening_rows[i])
      send_item(opening_rows[i].chr, opening_rows[i].eol, opening_rows[i].n_fix,
                opening_rows[i].fix0, opening_rows[i].fix1);

    for (int p = 0; p < PHASES; p++) begin
      wait_quiet();
      if (p == PHASES - 1) begin
        phase_delim[p] = 8'($urandom_range(255));
        phase_quote[p] = 8'($urandom_range(255));
      end
      write_reg(CFG_DELIM, phase_delim[p]);
      write_reg(CFG_QUOTE, phase_quote[p]);
      // receiver-heavy idling, then sender-heavy, then none
      send_idle_pct = (p < 2) ? 31 : (p < 4) ? 54 : 0;
      recv_idle_pct = (p < 2) ? 54 : (p < 4) ? 31 : 0;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        build_line();
        foreach (line_q[k])
          send_item(line_q[k], k == line_q.size() - 1, 2'd0, NO_RES, NO_RES);
        sent += line_q.size();
      end
    end

    // drain, then give stray results a chance to show up
    in_valid <= 1'b0;
    drain = 0;
    while (tokens_due.size() != 0 && drain < 100000) begin
      @(posedge clk);
      drain++;
    end
    repeat (4 * SETTLE) @(posedge clk);
    while (tokens_due.size() != 0) report_bad("missing result", tokens_due.pop_front(), NO_RES);
    if (fail_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

  // hard stop
  initial begin
    #2000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
